// File: rtl/feal_pkg.sv
// Package: shared function codes and status codes for the page allocator.
`timescale 1ns / 1ps
package feal_pkg;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_ADD   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

endpackage

// File: rtl/feal_datapath.sv
// Datapath: extent table memory, table read registers and extent count register.
`timescale 1ns / 1ps
module feal_datapath #(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_BITS   = 12,
    parameter int ADDR_BITS   = 52,
    parameter int IDX_BITS    = 6,
    parameter int CNT_BITS    = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mem_we,
    input  logic [IDX_BITS-1:0]          mem_waddr,
    input  logic [ADDR_BITS-PAGE_BITS:0] mem_wsp,
    input  logic [ADDR_BITS-PAGE_BITS:0] mem_wnp,
    input  logic                         mem_re,
    input  logic [IDX_BITS-1:0]          mem_raddr,
    output logic [ADDR_BITS-PAGE_BITS:0] mem_rsp,
    output logic [ADDR_BITS-PAGE_BITS:0] mem_rnp,
    input  logic                         cnt_we,
    input  logic [CNT_BITS-1:0]          cnt_next,
    output logic [CNT_BITS-1:0]          cnt
);
    // page numbers carry one spare bit so that the page limit itself fits
    localparam int PW = ADDR_BITS - PAGE_BITS + 1;

    logic [PW-1:0] sp_mem [MAX_EXTENTS];
    logic [PW-1:0] np_mem [MAX_EXTENTS];
    logic [PW-1:0] rsp_reg;
    logic [PW-1:0] rnp_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sp_mem[mem_waddr] <= mem_wsp;
            np_mem[mem_waddr] <= mem_wnp;
        end
        if (mem_re)
        begin
            rsp_reg <= sp_mem[mem_raddr];
            rnp_reg <= np_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cnt_we)
            cnt_reg <= cnt_next;
    end

    assign mem_rsp = rsp_reg;
    assign mem_rnp = rnp_reg;
    assign cnt     = cnt_reg;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_EXTENTS))
        else $error("extent count beyond table depth");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |=> (cnt_reg == $past(cnt_next)))
        else $error("extent count not updated");
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cnt_we |=> $stable(cnt_reg))
        else $error("extent count moved without update");
`endif
endmodule

// File: rtl/feal_ctrl.sv
// Controller: command sequencing, table scan, shift loops and result register.
`timescale 1ns / 1ps
module feal_ctrl #(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_BITS   = 12,
    parameter int ADDR_BITS   = 52,
    parameter int IDX_BITS    = 6,
    parameter int CNT_BITS    = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_func,
    input  logic [51:0]                  in_addr,
    input  logic [51:0]                  in_size,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   out_status,
    output logic [51:0]                  out_addr,
    output logic                         mem_we,
    output logic [IDX_BITS-1:0]          mem_waddr,
    output logic [ADDR_BITS-PAGE_BITS:0] mem_wsp,
    output logic [ADDR_BITS-PAGE_BITS:0] mem_wnp,
    output logic                         mem_re,
    output logic [IDX_BITS-1:0]          mem_raddr,
    input  logic [ADDR_BITS-PAGE_BITS:0] mem_rsp,
    input  logic [ADDR_BITS-PAGE_BITS:0] mem_rnp,
    output logic                         cnt_we,
    output logic [CNT_BITS-1:0]          cnt_next,
    input  logic [CNT_BITS-1:0]          cnt
);
    localparam int PW = ADDR_BITS - PAGE_BITS + 1;
    localparam logic [PW-1:0] LIMIT = PW'(1) << (ADDR_BITS - PAGE_BITS);
    localparam logic [CNT_BITS-1:0] MAXC = CNT_BITS'(MAX_EXTENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_ARD, S_AEV, S_FRD, S_FEV, S_FPRD, S_FPEV,
        S_MERGE, S_RMRD, S_RMWR, S_INRD, S_INWR, S_PUT, S_DONE
    } state_t;

    state_t state_reg;
    logic [1:0]          func_reg;
    logic [PW-1:0]       sp_reg, np_reg;    // command extent in pages
    logic [CNT_BITS-1:0] idx_reg;           // scan / shift index
    logic [CNT_BITS-1:0] pos_reg;           // insert or remove position
    logic [PW-1:0]       nnp_reg;           // length of entry at pos (free)
    logic                mn_reg;            // joins next entry
    logic [1:0]          status_reg;
    logic [51:0]         res_reg;
    logic                ovalid_reg;

    // command page arithmetic (one wide add/compare per path)
    logic [ADDR_BITS-1:0] a_in, s_in;
    logic [PAGE_BITS-1:0] off;
    logic [PW-1:0]        need, fsp, bsp, bnp_raw, room_f, room_b;
    logic [ADDR_BITS:0]   lead;
    logic [ADDR_BITS-1:0] rem;

    always_comb
    begin
        a_in = ADDR_BITS'(in_addr);
        s_in = ADDR_BITS'(in_size);
        off  = a_in[PAGE_BITS-1:0];
        need = PW'(s_in >> PAGE_BITS) + PW'(s_in[PAGE_BITS-1:0] != '0);
        fsp  = PW'(a_in >> PAGE_BITS);
        bsp  = fsp + PW'(off != '0);
        lead = (off != '0) ? ((ADDR_BITS+1)'(1) << PAGE_BITS) - (ADDR_BITS+1)'(off)
                           : '0;
        rem  = s_in - lead[ADDR_BITS-1:0];
        bnp_raw = PW'(rem >> PAGE_BITS);
        room_f = LIMIT - fsp;
        room_b = LIMIT - bsp;
    end

    // skip flag for commands that do nothing
    logic          cmd_skip;
    logic [PW-1:0] cmd_np, cmd_sp;
    always_comb
    begin
        cmd_skip = 1'b0;
        cmd_sp   = fsp;
        cmd_np   = need;
        unique case (in_func)
            feal_pkg::FUNC_ALLOC: cmd_skip = (need == '0);
            feal_pkg::FUNC_FREE:
            begin
                if (need > room_f)
                    cmd_np = room_f;
                cmd_skip = (need == '0);
            end
            feal_pkg::FUNC_ADD:
            begin
                cmd_sp = bsp;
                cmd_np = (bnp_raw > room_b) ? room_b : bnp_raw;
                cmd_skip = !(bsp < LIMIT) || ((ADDR_BITS+1)'(s_in) < lead)
                           || (cmd_np == '0);
            end
            default: cmd_skip = 1'b1;
        endcase
    end

    logic [CNT_BITS-1:0] idx_dec, idx_inc;
    assign idx_dec = idx_reg - CNT_BITS'(1);
    assign idx_inc = idx_reg + CNT_BITS'(1);

    // page taken from the top of the extent under test, as a byte address
    logic [PW-1:0]           alloc_pg;
    logic [PW+PAGE_BITS-1:0] alloc_byte;
    assign alloc_pg   = mem_rsp + mem_rnp - np_reg;
    assign alloc_byte = {alloc_pg, {PAGE_BITS{1'b0}}};

    // entry pos-1 (held in the read register) ends where the freed extent starts
    logic mp_hit;
    assign mp_hit = (pos_reg != '0) && (mem_rsp + mem_rnp == sp_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[IDX_BITS-1:0];
        mem_wsp   = mem_rsp;
        mem_wnp   = mem_rnp;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[IDX_BITS-1:0];
        cnt_we    = 1'b0;
        cnt_next  = cnt;
        unique case (state_reg)
            S_ARD, S_FRD: mem_re = 1'b1;
            S_FPRD:
            begin
                mem_re = 1'b1;
                mem_raddr = idx_dec[IDX_BITS-1:0];
            end
            S_RMRD:
            begin
                mem_re = 1'b1;
                mem_raddr = idx_inc[IDX_BITS-1:0];
            end
            S_RMWR: mem_we = 1'b1;
            S_INRD:
            begin
                mem_re = 1'b1;
                mem_raddr = idx_dec[IDX_BITS-1:0];
            end
            S_INWR: mem_we = 1'b1;
            default: ;
        endcase
        if (state_reg == S_MERGE)
        begin
            if (mp_hit)
            begin
                // join with preceding entry (and following one when it touches too)
                mem_we    = 1'b1;
                mem_waddr = idx_dec[IDX_BITS-1:0];
                mem_wsp   = mem_rsp;
                mem_wnp   = mem_rnp + np_reg + (mn_reg ? nnp_reg : '0);
            end
            else if (mn_reg)
            begin
                // join with following entry only
                mem_we    = 1'b1;
                mem_waddr = pos_reg[IDX_BITS-1:0];
                mem_wsp   = sp_reg;
                mem_wnp   = nnp_reg + np_reg;
            end
        end
        if (state_reg == S_PUT)
        begin
            mem_we    = 1'b1;
            mem_waddr = pos_reg[IDX_BITS-1:0];
            mem_wsp   = sp_reg;
            mem_wnp   = np_reg;
            cnt_we    = 1'b1;
            cnt_next  = cnt + CNT_BITS'(1);
        end
        if (state_reg == S_AEV && mem_rnp == np_reg)
        begin
            // exact fit: entry leaves via the remove loop
        end
        else if (state_reg == S_AEV && mem_rnp > np_reg)
        begin
            mem_we  = 1'b1;
            mem_wnp = mem_rnp - np_reg;
        end
        if (state_reg == S_RMRD && idx_inc >= cnt)
        begin
            mem_re   = 1'b0;
            cnt_we   = 1'b1;
            cnt_next = cnt - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            status_reg <= feal_pkg::ST_OK;
            res_reg    <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            mn_reg     <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && !ovalid_reg)
                    begin
                        func_reg   <= in_func;
                        sp_reg     <= cmd_sp;
                        np_reg     <= cmd_np;
                        idx_reg    <= '0;
                        res_reg    <= '0;
                        status_reg <= (in_func == feal_pkg::FUNC_ALLOC) ?
                                      feal_pkg::ST_NOFIT : feal_pkg::ST_OK;
                        if (cmd_skip)
                            state_reg <= S_DONE;
                        else if (in_func == feal_pkg::FUNC_ALLOC)
                            state_reg <= S_PREP;
                        else if (in_func == feal_pkg::FUNC_FREE)
                            state_reg <= S_FRD;
                        else
                            state_reg <= S_PREP;
                    end
                S_PREP:
                    if (func_reg == feal_pkg::FUNC_ADD)
                    begin
                        if (cnt >= MAXC)
                        begin
                            status_reg <= feal_pkg::ST_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            pos_reg   <= cnt;
                            idx_reg   <= cnt;
                            state_reg <= S_PUT;
                        end
                    end
                    else
                        state_reg <= (cnt == '0) ? S_DONE : S_ARD;
                S_ARD: state_reg <= S_AEV;
                S_AEV:
                    if (mem_rnp >= np_reg)
                    begin
                        status_reg <= feal_pkg::ST_OK;
                        res_reg    <= 52'(alloc_byte);
                        if (mem_rnp == np_reg)
                            state_reg <= S_RMRD;
                        else
                            state_reg <= S_DONE;
                    end
                    else if (idx_inc >= cnt)
                        state_reg <= S_DONE;
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_ARD;
                    end
                S_FRD:
                    if (idx_reg >= cnt)
                    begin
                        mn_reg    <= 1'b0;
                        pos_reg   <= idx_reg;
                        state_reg <= (idx_reg == '0) ? S_MERGE : S_FPRD;
                    end
                    else
                        state_reg <= S_FEV;
                S_FEV:
                    if (mem_rsp < sp_reg)
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        mn_reg    <= (sp_reg + np_reg == mem_rsp);
                        nnp_reg   <= mem_rnp;
                        pos_reg   <= idx_reg;
                        state_reg <= (idx_reg == '0) ? S_MERGE : S_FPRD;
                    end
                S_FPRD: state_reg <= S_FPEV;
                S_FPEV:
                    // mem_rsp/rnp now hold entry pos-1
                    if (mem_rsp + mem_rnp == sp_reg)
                        state_reg <= S_MERGE;
                    else if (mn_reg)
                        state_reg <= S_MERGE;
                    else
                    begin
                        idx_reg   <= cnt;
                        state_reg <= S_INRD;
                    end
                S_MERGE:
                begin
                    // reached with pos==idx; read register holds entry pos-1 when pos!=0
                    if (mp_hit)
                    begin
                        if (mn_reg)
                        begin
                            idx_reg   <= pos_reg;
                            state_reg <= S_RMRD;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else if (mn_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        idx_reg   <= cnt;
                        state_reg <= S_INRD;
                    end
                end
                S_RMRD:
                    if (idx_inc >= cnt)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RMWR;
                S_RMWR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_RMRD;
                end
                S_INRD:
                    if (cnt >= MAXC)
                    begin
                        status_reg <= feal_pkg::ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else if (idx_reg <= pos_reg)
                        state_reg <= S_PUT;
                    else
                        state_reg <= S_INWR;
                S_INWR:
                begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_INRD;
                end
                S_PUT: state_reg <= S_DONE;
                S_DONE:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid  = ovalid_reg;
    assign out_status = status_reg;
    assign out_addr   = res_reg;

`ifndef NO_ASSERTIONS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !in_ready)
        else $error("command taken while result pending");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> ovalid_reg)
        else $error("result not raised after command");
    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (cnt < MAXC))
        else $error("insert into full table");
`endif
endmodule

// File: rtl/free_extent_page_allocator_unit.sv
// Top level: first-fit free extent page allocator with coalescing.
// An ignored command goes from acceptance through the done state to the result;
// otherwise time to result valid grows with the entries scanned or moved, each
// taking a read state and an evaluate or write state. Set by the single-port table, one read a cycle.
// Throughput: one command at a time; a new command is taken once the
// previous result transfer is done.
// Reset: rst_n asynchronous, clears extent count and handshake state; the
// extent table itself is not cleared, only entries below the count are read.
`timescale 1ns / 1ps
module free_extent_page_allocator_unit #(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_BITS   = 12,
    parameter int ADDR_BITS   = 52
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,  // func[1:0], address[53:2], size_bytes[105:54]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [55:0]   m_axis_tdata   // status[1:0], alloc_address[53:2]
);
    localparam int IDX_BITS = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_BITS = $clog2(MAX_EXTENTS + 1);
    localparam int PW       = ADDR_BITS - PAGE_BITS + 1;

    logic                mem_we, mem_re, cnt_we;
    logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
    logic [PW-1:0]       mem_wsp, mem_wnp, mem_rsp, mem_rnp;
    logic [CNT_BITS-1:0] cnt_next, cnt;
    logic [1:0]          out_status;
    logic [51:0]         out_addr;

    feal_ctrl #(
        .MAX_EXTENTS(MAX_EXTENTS), .PAGE_BITS(PAGE_BITS), .ADDR_BITS(ADDR_BITS),
        .IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_func(s_axis_tdata[1:0]), .in_addr(s_axis_tdata[53:2]),
        .in_size(s_axis_tdata[105:54]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(out_status), .out_addr(out_addr),
        .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wsp(mem_wsp), .mem_wnp(mem_wnp),
        .mem_re(mem_re), .mem_raddr(mem_raddr), .mem_rsp(mem_rsp), .mem_rnp(mem_rnp),
        .cnt_we(cnt_we), .cnt_next(cnt_next), .cnt(cnt)
    );

    feal_datapath #(
        .MAX_EXTENTS(MAX_EXTENTS), .PAGE_BITS(PAGE_BITS), .ADDR_BITS(ADDR_BITS),
        .IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wsp(mem_wsp), .mem_wnp(mem_wnp),
        .mem_re(mem_re), .mem_raddr(mem_raddr), .mem_rsp(mem_rsp), .mem_rnp(mem_rnp),
        .cnt_we(cnt_we), .cnt_next(cnt_next), .cnt(cnt)
    );

    assign m_axis_tdata = {2'b00, out_addr, out_status};
endmodule
